// ===== rtl/thermo_pkg.sv =====
// shared types, constants and register codes of the ntc temperature converter
package thermo_pkg;

    // fixed field widths
    localparam int ADC_W    = 12;
    localparam int FS_W     = 16;
    localparam int TEMP_W   = 18;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // default full-scale converter code
    localparam int ADC_FULL_SCALE_DEF = 4095;

    // log2 pipeline: one normalize stage plus one stage per fraction bit
    localparam int LOG_FRAC_W = 28;
    localparam int LOG_W      = 33;
    localparam int LOG_LAT    = LOG_FRAC_W + 1;

    // arithmetic constants
    localparam logic [29:0] LN2_Q30        = 30'd744261118;
    localparam logic [16:0] KELVIN_OFFSET  = 17'd27315;
    localparam logic [16:0] TK_LIMIT       = 17'd127316;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 18'sd100000;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -18'sd27315;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SERIES   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOM_TEMP = 8'd3;

    // register reset values
    localparam logic [15:0] SERIES_RST   = 16'd10000;
    localparam logic [15:0] BETA_RST     = 16'd3950;
    localparam logic [15:0] NOMINAL_RST  = 16'd10000;
    localparam logic [7:0]  NOM_TEMP_RST = 8'd25;

    // sideband through the log stages
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                num_zero;
        logic                den_zero;
    } t_side;

    // sideband after the log stages
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                force_max;
        logic                force_min;
    } t_flag;

endpackage

// ===== rtl/thermo_if.sv =====
// stream and configuration interfaces of the ntc temperature converter

interface thermo_in_if;
    logic                            valid;
    logic                            ready;
    logic [thermo_pkg::ADC_W-1:0]    adc_value;
    modport source (output valid, output adc_value, input ready);
    modport sink   (input valid, input adc_value, output ready);
endinterface

interface thermo_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [thermo_pkg::TEMP_W-1:0]   temperature_centi;
    logic [thermo_pkg::STATUS_W-1:0]        status;
    modport source (output valid, output temperature_centi, output status, input ready);
    modport sink   (input valid, input temperature_centi, input status, output ready);
endinterface

interface thermo_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [thermo_pkg::CFG_IDX_W-1:0]     index;
    logic [thermo_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/thermo_log2.sv =====
// pipelined base-2 logarithm in q28 by leading-one search and repeated squaring
module thermo_log2 (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [31:0]                       i_x,
    output logic [thermo_pkg::LOG_W-1:0]      o_log
);
    localparam int NF = thermo_pkg::LOG_FRAC_W;

    logic [4:0]    n_e;
    logic [31:0]   n_m;
    logic [31:0]   r_m [NF+1];
    logic [4:0]    r_e [NF+1];
    logic [NF-1:0] r_f [NF+1];

    // leading-one position and normalized mantissa
    always_comb begin
        n_e = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (i_x[k]) begin
                n_e = 5'(k);
            end
        end
        n_m = i_x << (5'd31 - n_e);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= n_m;
            r_e[0] <= n_e;
            r_f[0] <= '0;
        end
    end

    // one fraction bit per stage
    for (genvar k = 1; k <= NF; k++) begin : g_sq
        logic [63:0] w_sq;
        logic [32:0] w_sh;
        assign w_sq = r_m[k-1] * r_m[k-1];
        assign w_sh = w_sq[63:31];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k] <= w_sh[32] ? w_sh[32:1] : w_sh[31:0];
                r_f[k] <= {r_f[k-1][NF-2:0], w_sh[32]};
                r_e[k] <= r_e[k-1];
            end
        end
    end

    assign o_log = {r_e[NF], r_f[NF]};

endmodule

// ===== rtl/ntc_adc_to_temperature_unit.sv =====
// top level of the ntc converter-reading to temperature pipeline
//
// Usage:
//   i_in carries one 12-bit converter reading per beat (adc_value); o_out
//   returns one beat per reading with temperature_centi (signed hundredths
//   of a degree Celsius, saturated to -27315..100000) and status (0 valid,
//   1 reading zero, 2 reading at or above full scale, temperature then 0).
//   i_cfg writes the series resistor, beta, nominal resistance and nominal
//   temperature by index and is always ready; it must be written only while
//   idle by the user, as the block itself does not enforce this.
// Throughput: one reading per cycle. The depth is set by the two 29-stage
//   log2 squaring pipelines and the 17-stage restoring divider.
// Reset: synchronous, active low; registers return to 10000 ohm, beta 3950,
//   10000 ohm at 25 C; the pipeline empties.
// Stall: when the output beat is held and not taken, the whole pipeline
//   holds and i_in.ready drops; nothing is lost or repeated.
module ntc_adc_to_temperature_unit #(
    parameter int ADC_FULL_SCALE = thermo_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    thermo_in_if.sink        i_in,
    thermo_out_if.source     o_out,
    thermo_cfg_if.sink       i_cfg
);
    localparam int LL       = thermo_pkg::LOG_LAT;
    localparam int NDIV     = 17;
    localparam int PIPE_LEN = 27 + LL;
    localparam logic [thermo_pkg::FS_W-1:0] FS = thermo_pkg::FS_W'(ADC_FULL_SCALE);

    // configuration registers
    logic [15:0] r_series, r_beta, r_nominal;
    logic [7:0]  r_nom_temp;
    logic [15:0] r_k0;
    logic [22:0] r_b100;
    logic [38:0] r_nbase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series   <= thermo_pkg::SERIES_RST;
            r_beta     <= thermo_pkg::BETA_RST;
            r_nominal  <= thermo_pkg::NOMINAL_RST;
            r_nom_temp <= thermo_pkg::NOM_TEMP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                thermo_pkg::REG_SERIES:   r_series   <= i_cfg.data;
                thermo_pkg::REG_BETA:     r_beta     <= i_cfg.data;
                thermo_pkg::REG_NOMINAL:  r_nominal  <= i_cfg.data;
                thermo_pkg::REG_NOM_TEMP: r_nom_temp <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // derived constants: nominal in centikelvin, 100*beta and their product
    always_ff @(posedge i_clk) begin
        r_k0    <= 16'(r_nom_temp * 16'd100) + 16'(thermo_pkg::KELVIN_OFFSET);
        r_b100  <= 23'(r_beta * 23'd100);
        r_nbase <= r_b100 * r_k0;
    end

    // global advance and valid bits
    logic                w_adv;
    logic [PIPE_LEN-1:0] r_vld;

    assign w_adv      = !r_vld[PIPE_LEN-1] || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_LEN-2:0], i_in.valid};
        end
    end

    // stage a: input register; stage b: divider products and status
    logic [thermo_pkg::ADC_W-1:0] r_a_adc;
    logic [31:0]                  r_b_num, r_b_den;
    thermo_pkg::t_side            r_b_side;
    logic [thermo_pkg::FS_W-1:0]  w_adc_ext;

    assign w_adc_ext = thermo_pkg::FS_W'(r_a_adc);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_adc  <= i_in.adc_value;
            r_b_num  <= 32'(r_series) * 32'(r_a_adc);
            r_b_den  <= 32'(r_nominal) * 32'(FS - w_adc_ext);
            r_b_side.num_zero <= (r_series == '0);
            r_b_side.den_zero <= (r_nominal == '0);
            if (r_a_adc == '0) begin
                r_b_side.status <= thermo_pkg::STATUS_ZERO;
            end else if (w_adc_ext >= FS) begin
                r_b_side.status <= thermo_pkg::STATUS_FULL;
            end else begin
                r_b_side.status <= thermo_pkg::STATUS_OK;
            end
        end
    end

    // log2 of numerator and denominator
    logic [thermo_pkg::LOG_W-1:0] w_ln_num, w_ln_den;

    thermo_log2 u_log_num (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_x   (r_b_num),
        .o_log (w_ln_num)
    );

    thermo_log2 u_log_den (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_x   (r_b_den),
        .o_log (w_ln_den)
    );

    // sideband delay matching the log pipelines
    thermo_pkg::t_side r_sb [LL];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sb[0] <= r_b_side;
            for (int k = 1; k < LL; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // stages c to i: ln ratio, beta denominator, overflow check
    logic [32:0]        r_c_mag;
    logic               r_c_neg, r_d_neg, r_e_neg, r_f_neg;
    thermo_pkg::t_flag  r_c_fl, r_d_fl, r_e_fl, r_f_fl, r_g_fl, r_h_fl, r_i_fl;
    logic [62:0]        r_d_prod;
    logic [24:0]        r_e_lmag;
    logic [40:0]        r_f_lk;
    logic [43:0]        r_g_d, r_h_d, r_i_d;
    logic [59:0]        r_g_sum, r_h_sum, r_i_rem;
    logic [60:0]        r_h_dx;
    logic [63:0]        w_round;
    logic signed [44:0] w_dsig;
    logic               w_dpos;

    assign w_round = 64'(r_d_prod) + 64'h20_0000_0000;
    assign w_dsig  = r_f_neg ? $signed({2'b0, r_b100, 20'b0}) - $signed({4'b0, r_f_lk})
                             : $signed({2'b0, r_b100, 20'b0}) + $signed({4'b0, r_f_lk});
    assign w_dpos  = !w_dsig[44] && (w_dsig != '0);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // c: magnitude of log difference
            r_c_neg <= w_ln_num < w_ln_den;
            r_c_mag <= (w_ln_num < w_ln_den) ? w_ln_den - w_ln_num : w_ln_num - w_ln_den;
            r_c_fl.status    <= r_sb[LL-1].status;
            r_c_fl.force_max <= r_sb[LL-1].num_zero;
            r_c_fl.force_min <= r_sb[LL-1].den_zero && !r_sb[LL-1].num_zero;
            // d: scale by ln 2
            r_d_prod <= r_c_mag * thermo_pkg::LN2_Q30;
            r_d_neg  <= r_c_neg;
            r_d_fl   <= r_c_fl;
            // e: round to q20
            r_e_lmag <= w_round[62:38];
            r_e_neg  <= r_d_neg;
            r_e_fl   <= r_d_fl;
            // f: times nominal centikelvin
            r_f_lk   <= r_e_lmag * r_k0;
            r_f_neg  <= r_e_neg;
            r_f_fl   <= r_e_fl;
            // g: denominator and rounded numerator
            r_g_d    <= w_dsig[43:0];
            r_g_sum  <= {1'b0, r_nbase, 20'b0} + 60'(w_dsig[43:1]);
            r_g_fl.status    <= r_f_fl.status;
            r_g_fl.force_min <= r_f_fl.force_min;
            r_g_fl.force_max <= r_f_fl.force_max || (!r_f_fl.force_min && !w_dpos);
            // h: denominator times limit
            r_h_dx   <= r_g_d * thermo_pkg::TK_LIMIT;
            r_h_d    <= r_g_d;
            r_h_sum  <= r_g_sum;
            r_h_fl   <= r_g_fl;
            // i: quotient at or above limit saturates
            r_i_d    <= r_h_d;
            r_i_rem  <= r_h_sum;
            r_i_fl.status    <= r_h_fl.status;
            r_i_fl.force_min <= r_h_fl.force_min;
            r_i_fl.force_max <= r_h_fl.force_max
                                || (!r_h_fl.force_min && ({1'b0, r_h_sum} >= r_h_dx));
        end
    end

    // restoring divider, one quotient bit per stage
    logic [59:0]       r_dv_rem [NDIV];
    logic [16:0]       r_dv_q   [NDIV];
    logic [43:0]       r_dv_d   [NDIV];
    thermo_pkg::t_flag r_dv_fl  [NDIV];

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        localparam int SH = NDIV - 1 - j;
        logic [59:0]       w_rem_in;
        logic [16:0]       w_q_in;
        logic [43:0]       w_d_in;
        thermo_pkg::t_flag w_fl_in;
        logic [60:0]       w_trial;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = r_i_rem;
            assign w_q_in   = '0;
            assign w_d_in   = r_i_d;
            assign w_fl_in  = r_i_fl;
        end else begin : g_next
            assign w_rem_in = r_dv_rem[j-1];
            assign w_q_in   = r_dv_q[j-1];
            assign w_d_in   = r_dv_d[j-1];
            assign w_fl_in  = r_dv_fl[j-1];
        end

        assign w_trial = 61'(w_d_in) << SH;
        assign w_ge    = {1'b0, w_rem_in} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_rem[j] <= w_ge ? 60'({1'b0, w_rem_in} - w_trial) : w_rem_in;
                r_dv_q[j]   <= {w_q_in[15:0], w_ge};
                r_dv_d[j]   <= w_d_in;
                r_dv_fl[j]  <= w_fl_in;
            end
        end
    end

    // output register
    logic signed [thermo_pkg::TEMP_W-1:0] r_out_temp;
    logic [thermo_pkg::STATUS_W-1:0]      r_out_status;
    thermo_pkg::t_flag                    w_last_fl;

    assign w_last_fl = r_dv_fl[NDIV-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status <= w_last_fl.status;
            if (w_last_fl.status != thermo_pkg::STATUS_OK) begin
                r_out_temp <= '0;
            end else if (w_last_fl.force_max) begin
                r_out_temp <= thermo_pkg::TEMP_MAX;
            end else if (w_last_fl.force_min) begin
                r_out_temp <= thermo_pkg::TEMP_MIN;
            end else begin
                r_out_temp <= $signed({1'b0, r_dv_q[NDIV-1]})
                              - $signed({1'b0, thermo_pkg::KELVIN_OFFSET});
            end
        end
    end

    assign o_out.valid             = r_vld[PIPE_LEN-1];
    assign o_out.temperature_centi = r_out_temp;
    assign o_out.status            = r_out_status;

`ifndef NO_ASSERTIONS
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output beat right after reset");

    a_fault_zero_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != thermo_pkg::STATUS_OK |-> r_out_temp == '0)
        else $error("fault beat with nonzero temperature");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_out_temp <= thermo_pkg::TEMP_MAX)
                        && (r_out_temp >= thermo_pkg::TEMP_MIN))
        else $error("temperature outside saturation range");

    a_quotient_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_LEN-2] && !w_last_fl.force_max && !w_last_fl.force_min
        |-> r_dv_q[NDIV-1] < thermo_pkg::TK_LIMIT)
        else $error("divider quotient beyond limit without saturation");
`endif

endmodule

// ===== bench/tb_ntc_adc_to_temperature_unit.sv =====
// self-checking bench for the ntc converter-reading to temperature pipeline
`timescale 1ns / 1ps

module tb_ntc_adc_to_temperature_unit;

    localparam int FULL_SCALE = thermo_pkg::ADC_FULL_SCALE_DEF;
    localparam int PIPE_LAT   = 27 + thermo_pkg::LOG_LAT;
    localparam int N_RANDOM   = 1200;

    typedef struct packed {
        logic signed [thermo_pkg::TEMP_W-1:0] temp;
        logic [thermo_pkg::STATUS_W-1:0]      status;
    } t_reading;

    // one directed row: reading, and an expected result when one is typed in
    typedef struct {
        logic [thermo_pkg::ADC_W-1:0] adc;
        bit                           typed;
        t_reading                     want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    thermo_in_if  in_ch ();
    thermo_out_if out_ch ();
    thermo_cfg_if cfg_ch ();

    ntc_adc_to_temperature_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // local copy of the divider and thermistor settings
    logic [15:0] series_ohm;
    logic [15:0] beta_k;
    logic [15:0] nominal_ohm;
    logic [7:0]  nominal_degc;

    t_reading temp_queue[$];
    int       mismatch_cnt;
    int       result_cnt;
    bit       hold_off;
    int       fault_cnt;
    int       sat_cnt;

    // log2 in q28: leading-one position plus squared-mantissa fraction
    function automatic logic [63:0] log2_q28(input logic [63:0] x);
        int          lead;
        logic [63:0] mant;
        logic [63:0] frac;
        lead = 0;
        frac = 0;
        while (lead < 31 && (x >> (lead + 1)) != 0)
            lead++;
        mant = x << (31 - lead);
        for (int i = 0; i < thermo_pkg::LOG_FRAC_W; i++) begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000) begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        return (64'(lead) << 28) | frac;
    endfunction

    // beta equation in hundredths of a degree Celsius, saturated to the output range
    function automatic logic signed [thermo_pkg::TEMP_W-1:0] beta_centi(
        input logic [thermo_pkg::ADC_W-1:0] adc);
        logic [63:0]        num, den, l_num, l_den, mag, k0, quo;
        logic signed [63:0] lq20, dsum, tc;
        bit                 neg;
        num = 64'(series_ohm) * 64'(adc);
        den = 64'(nominal_ohm) * 64'(FULL_SCALE - adc);
        if (num == 0) return thermo_pkg::TEMP_MAX;
        if (den == 0) return thermo_pkg::TEMP_MIN;
        l_num = log2_q28(num);
        l_den = log2_q28(den);
        neg = l_num < l_den;
        mag = neg ? l_den - l_num : l_num - l_den;
        mag = (mag * 64'(thermo_pkg::LN2_Q30) + (64'd1 << 37)) >> 38;
        lq20 = neg ? -$signed(mag) : $signed(mag);
        k0 = 100 * 64'(nominal_degc) + 64'(thermo_pkg::KELVIN_OFFSET);
        dsum = lq20 * $signed(k0) + $signed((100 * 64'(beta_k)) << 20);
        if (dsum <= 0) return thermo_pkg::TEMP_MAX;
        quo = (100 * 64'(beta_k) * k0) << 20;
        quo = (quo + (dsum >>> 1)) / dsum;
        if (quo > 64'(thermo_pkg::TK_LIMIT)) return thermo_pkg::TEMP_MAX;
        tc = $signed(quo) - 27315;
        if (tc < -27315) tc = -27315;
        if (tc > 100000) tc = 100000;
        return tc[thermo_pkg::TEMP_W-1:0];
    endfunction

    function automatic t_reading predict_reading(input logic [thermo_pkg::ADC_W-1:0] adc);
        t_reading r;
        r.temp = '0;
        r.status = thermo_pkg::STATUS_OK;
        if (adc == 0) r.status = thermo_pkg::STATUS_ZERO;
        else if (adc >= FULL_SCALE) r.status = thermo_pkg::STATUS_FULL;
        else r.temp = beta_centi(adc);
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(20ns * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // one configuration beat, then valid low before returning
    task automatic write_reg(input logic [thermo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            thermo_pkg::REG_SERIES:   series_ohm   = val;
            thermo_pkg::REG_BETA:     beta_k       = val;
            thermo_pkg::REG_NOMINAL:  nominal_ohm  = val;
            thermo_pkg::REG_NOM_TEMP: nominal_degc = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        while (temp_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    task automatic set_all(input logic [15:0] s, b, n, input logic [7:0] t);
        drain_pipe();
        write_reg(thermo_pkg::REG_SERIES, s);
        write_reg(thermo_pkg::REG_BETA, b);
        write_reg(thermo_pkg::REG_NOMINAL, n);
        write_reg(thermo_pkg::REG_NOM_TEMP, {8'd0, t});
    endtask

    // send one reading beat; valid stays up into a following beat with no gap
    task automatic send_reading(input logic [thermo_pkg::ADC_W-1:0] adc, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.adc_value <= adc;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        temp_queue.push_back(predict_reading(adc));
    endtask

    // random reading: mostly uniform over the full range, sometimes the ends
    function automatic logic [thermo_pkg::ADC_W-1:0] pick_reading();
        case ($urandom_range(0, 9))
            0: return thermo_pkg::ADC_W'($urandom_range(0, 3));
            1: return thermo_pkg::ADC_W'($urandom_range(FULL_SCALE - 3, 4095));
            default: return thermo_pkg::ADC_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // typed check of the predictor on an extreme setting
    task automatic check_extreme(input logic [thermo_pkg::ADC_W-1:0] adc,
                                 input logic signed [thermo_pkg::TEMP_W-1:0] want);
        t_reading got;
        got = predict_reading(adc);
        if (got.temp != want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("extreme reading %0d: temp exp %0d got %0d", adc, want, got.temp);
        end
    endtask

    // receiver: random stalls, or a long hold-off while requested
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_reading want;
            if (temp_queue.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result beat: temp %0d status %0d",
                             out_ch.temperature_centi, out_ch.status);
            end else begin
                want = temp_queue.pop_front();
                result_cnt++;
                if (want.status != thermo_pkg::STATUS_OK) fault_cnt++;
                if (want.temp == thermo_pkg::TEMP_MAX || want.temp == thermo_pkg::TEMP_MIN)
                    sat_cnt++;
                if (out_ch.temperature_centi !== want.temp
                    || out_ch.status !== want.status) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: temp exp %0d got %0d, status exp %0d got %0d",
                                 want.temp, out_ch.temperature_centi,
                                 want.status, out_ch.status);
                end
            end
        end
    end

    // stimulus
    initial begin
        t_row rows[$];
        t_row row;
        int   wait_cnt;
        mismatch_cnt = 0;
        result_cnt   = 0;
        fault_cnt    = 0;
        sat_cnt      = 0;
        hold_off     = 1'b0;
        series_ohm   = thermo_pkg::SERIES_RST;
        beta_k       = thermo_pkg::BETA_RST;
        nominal_ohm  = thermo_pkg::NOMINAL_RST;
        nominal_degc = thermo_pkg::NOM_TEMP_RST;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.adc_value <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows with reset settings; typed results for faults
        rows = '{
            '{12'd0,    1'b1, '{18'sd0, thermo_pkg::STATUS_ZERO}},
            '{12'd4095, 1'b1, '{18'sd0, thermo_pkg::STATUS_FULL}},
            '{12'd1,    1'b0, '{18'sd0, thermo_pkg::STATUS_OK}},
            '{12'd2047, 1'b0, '{18'sd0, thermo_pkg::STATUS_OK}},
            '{12'd2048, 1'b0, '{18'sd0, thermo_pkg::STATUS_OK}},
            '{12'd4094, 1'b0, '{18'sd0, thermo_pkg::STATUS_OK}},
            '{12'd1365, 1'b0, '{18'sd0, thermo_pkg::STATUS_OK}},
            '{12'd2730, 1'b0, '{18'sd0, thermo_pkg::STATUS_OK}},
            '{12'hAAA,  1'b0, '{18'sd0, thermo_pkg::STATUS_OK}},
            '{12'h555,  1'b0, '{18'sd0, thermo_pkg::STATUS_OK}}
        };
        foreach (rows[i]) begin
            row = rows[i];
            send_reading(row.adc, 1'b0);
            if (row.typed && predict_reading(row.adc) != row.want) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("predictor disagrees with table row %0d", i);
            end
        end

        // extremes: zero series, zero nominal, zero beta, maxima, mixed minima, unused index
        set_all(16'd0, thermo_pkg::BETA_RST, thermo_pkg::NOMINAL_RST,
                thermo_pkg::NOM_TEMP_RST);
        send_reading(12'd100, 1'b0);
        check_extreme(12'd100, thermo_pkg::TEMP_MAX);
        set_all(thermo_pkg::SERIES_RST, thermo_pkg::BETA_RST, 16'd0,
                thermo_pkg::NOM_TEMP_RST);
        send_reading(12'd100, 1'b0);
        check_extreme(12'd100, thermo_pkg::TEMP_MIN);
        set_all(thermo_pkg::SERIES_RST, 16'd0, thermo_pkg::NOMINAL_RST, 8'd150);
        send_reading(12'd10, 1'b0);
        send_reading(12'd4000, 1'b0);
        set_all(16'd65535, 16'd65535, 16'd65535, 8'd255);
        send_reading(12'd1, 1'b0);
        send_reading(12'd4094, 1'b0);
        set_all(16'd1, 16'd1, 16'd65535, 8'd0);
        send_reading(12'd1, 1'b0);
        send_reading(12'd4094, 1'b0);
        set_all(16'd65535, 16'd1, 16'd1, 8'd0);
        send_reading(12'd4094, 1'b0);
        drain_pipe();
        write_reg(8'd200, 16'hFFFF);

        // random phases under varied settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0)
                set_all(thermo_pkg::SERIES_RST, thermo_pkg::BETA_RST,
                        thermo_pkg::NOMINAL_RST, thermo_pkg::NOM_TEMP_RST);
            else
                set_all(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                        16'($urandom_range(1, 65535)), 8'($urandom_range(0, 255)));
            if (ph == 1) hold_off = 1'b1;
            for (int k = 0; k < N_RANDOM / 8; k++)
                send_reading(pick_reading(), (ph % 3) != 2);
        end

        // final drain, bounded
        in_ch.valid <= 1'b0;
        wait_cnt = 0;
        while (temp_queue.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (PIPE_LAT + 8) @(posedge i_clk);
        $display("checked %0d result beats, %0d faults, %0d saturated, over 14 settings",
                 result_cnt, fault_cnt, sat_cnt);
        if (mismatch_cnt == 0 && temp_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_cnt, temp_queue.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/thermo_pkg.sv
rtl/thermo_if.sv
rtl/thermo_log2.sv
rtl/ntc_adc_to_temperature_unit.sv
bench/tb_ntc_adc_to_temperature_unit.sv
